### design/iohd_pkg.sv
// Shared constants, result codes and controller/datapath handshake types.
package iohd_pkg;
	localparam int QDEPTH = 16;
	localparam int IDX_W  = $clog2(QDEPTH);
	localparam int SLOT_W = 4;
	localparam int OFF_W  = 48;
	localparam int LEN_W  = 32;
	localparam int SEQ_W  = 32;
	localparam int RK_W   = 3;

	localparam logic [RK_W-1:0] RK_ENQ_OK   = 3'd0;
	localparam logic [RK_W-1:0] RK_FULL     = 3'd1;
	localparam logic [RK_W-1:0] RK_CPL_OK   = 3'd2;
	localparam logic [RK_W-1:0] RK_CPL_REJ  = 3'd3;
	localparam logic [RK_W-1:0] RK_DISPATCH = 3'd4;

	localparam logic KIND_ENQ = 1'b0;

	typedef logic [QDEPTH-1:0] qmask_t;

	typedef struct packed {
		logic take;
		logic check;
		logic cmp;
		logic upd;
		logic calc;
		logic emit1;
		logic scan;
	} cmd_t;

	typedef struct packed {
		logic enq_go;
		logic j_last;
		logic disp_none;
		logic out_free;
		logic scan_last;
	} sts_t;
endpackage

### design/iohd_if.sv
// Word channel interfaces for requests and results.
interface iohd_req_if import iohd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic             is_write;
	logic [OFF_W-1:0] offset;
	logic [LEN_W-1:0] length;
	logic [SLOT_W-1:0] slot;
	modport source (output valid, kind, is_write, offset, length, slot, input ready);
	modport sink (input valid, kind, is_write, offset, length, slot, output ready);
endinterface

interface iohd_rsp_if import iohd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RK_W-1:0]   result_kind;
	logic [SLOT_W-1:0] out_slot;
	logic [SEQ_W-1:0]  sequence_res;
	logic              out_is_write;
	logic [OFF_W-1:0]  out_offset;
	logic [LEN_W-1:0]  out_length;
	logic              last;
	modport source (output valid, result_kind, out_slot, sequence_res, out_is_write,
		out_offset, out_length, last, input ready);
	modport sink (input valid, result_kind, out_slot, sequence_res, out_is_write,
		out_offset, out_length, last, output ready);
endinterface

### design/iohd_ctrl.sv
// Sequencing state machine for one word from accept to its last result.
module iohd_ctrl import iohd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd,
	input  logic in_valid,
	output logic in_ready
);
	typedef enum logic [2:0] {IDLE, CHECK, CMP, UPD, CALC, EMIT1, SCAN} state_t;
	state_t state_q;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd       = '0;
		cmd.take  = (state_q == IDLE) && in_valid;
		cmd.check = (state_q == CHECK);
		cmd.cmp   = (state_q == CMP);
		cmd.upd   = (state_q == UPD);
		cmd.calc  = (state_q == CALC);
		cmd.emit1 = (state_q == EMIT1) && sts.out_free;
		cmd.scan  = (state_q == SCAN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			case (state_q)
				IDLE:  if (in_valid) state_q <= CHECK;
				CHECK: state_q <= sts.enq_go ? CMP : UPD;
				CMP:   if (sts.j_last) state_q <= UPD;
				UPD:   state_q <= CALC;
				CALC:  state_q <= EMIT1;
				EMIT1: if (sts.out_free) state_q <= sts.disp_none ? IDLE : SCAN;
				SCAN:  if (sts.out_free && sts.scan_last) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	a_cmp_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CMP |=> state_q == CMP || state_q == UPD) else $error("cmp exit");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == CHECK) else $error("take");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.check, cmd.cmp, cmd.upd, cmd.calc, cmd.emit1, cmd.scan}))
		else $error("cmd");
endmodule

### design/iohd_dp.sv
// Queue storage, hazard matrix, dispatch selection and result register.
module iohd_dp import iohd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	iohd_req_if.sink   req,
	iohd_rsp_if.source rsp
);
	qmask_t valid_q, run_q, disp_q, conf_row_q;
	qmask_t older_q [QDEPTH];
	qmask_t conf_q  [QDEPTH];
	logic             ewr_q    [QDEPTH];
	logic [OFF_W-1:0] estart_q [QDEPTH];
	logic [LEN_W-1:0] esize_q  [QDEPTH];
	logic [SEQ_W-1:0] eseq_q   [QDEPTH];

	logic             kind_q, wr_q;
	logic [OFF_W-1:0] off_q;
	logic [LEN_W-1:0] len_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SEQ_W-1:0] next_seq_q;
	logic [IDX_W-1:0] j_q, free_q;
	logic             enq_go_q, cpl_ok_q;
	logic [RK_W-1:0]  rk_q;
	logic [SLOT_W-1:0] rslot_q;
	logic [SEQ_W-1:0] rseq_q;
	logic             ov_q;

	logic [IDX_W-1:0] free_idx, pick_idx, rd_idx;
	logic             full, cpl_ok, hit;
	qmask_t           pick, blocked;
	logic [OFF_W:0]   a_end, b_end;

	always_comb begin
		free_idx = '0;
		for (int i = QDEPTH - 1; i >= 0; i--)
			if (!valid_q[i]) free_idx = IDX_W'(i);
	end
	assign full   = &valid_q;
	assign cpl_ok = ({1'b0, slot_q} < (SLOT_W+1)'(QDEPTH)) &&
		valid_q[slot_q[IDX_W-1:0]] && run_q[slot_q[IDX_W-1:0]];

	always_comb begin
		for (int i = 0; i < QDEPTH; i++) begin
			blocked[i] = |(conf_q[i] & older_q[i] & valid_q);
			pick[i]    = disp_q[i] && ((older_q[i] & disp_q) == '0);
		end
		pick_idx = '0;
		for (int i = 0; i < QDEPTH; i++)
			if (pick[i]) pick_idx = pick_idx | IDX_W'(i);
	end

	assign rd_idx = cmd.cmp ? j_q : pick_idx;
	assign a_end  = {1'b0, off_q} + {{(OFF_W+1-LEN_W){1'b0}}, len_q};
	assign b_end  = {1'b0, estart_q[rd_idx]} + {{(OFF_W+1-LEN_W){1'b0}}, esize_q[rd_idx]};
	assign hit    = valid_q[rd_idx] && (wr_q || ewr_q[rd_idx]) &&
		!((a_end < {1'b0, estart_q[rd_idx]}) || (b_end < {1'b0, off_q}));

	assign sts.enq_go    = (kind_q == KIND_ENQ) && !full;
	assign sts.j_last    = (j_q == IDX_W'(QDEPTH - 1));
	assign sts.disp_none = (disp_q == '0);
	assign sts.out_free  = !ov_q || rsp.ready;
	assign sts.scan_last = ((disp_q & ~pick) == '0);

	assign req.ready = cmd.take;
	assign rsp.valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			run_q      <= '0;
			disp_q     <= '0;
			next_seq_q <= '0;
			ov_q       <= 1'b0;
			for (int i = 0; i < QDEPTH; i++) older_q[i] <= '0;
		end else begin
			if (cmd.upd && enq_go_q) begin
				valid_q[free_q] <= 1'b1;
				run_q[free_q]   <= 1'b0;
				older_q[free_q] <= valid_q;
				next_seq_q      <= next_seq_q + 1'b1;
			end
			if (cmd.upd && cpl_ok_q) begin
				valid_q[slot_q[IDX_W-1:0]] <= 1'b0;
				run_q[slot_q[IDX_W-1:0]]   <= 1'b0;
				for (int i = 0; i < QDEPTH; i++)
					older_q[i][slot_q[IDX_W-1:0]] <= 1'b0;
				older_q[slot_q[IDX_W-1:0]] <= '0;
			end
			if (cmd.calc) begin
				disp_q <= valid_q & ~run_q & ~blocked;
				run_q  <= run_q | (valid_q & ~run_q & ~blocked);
			end
			if (cmd.scan) disp_q <= disp_q & ~pick;
			if (cmd.emit1 || cmd.scan) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= req.kind;
			wr_q   <= req.is_write;
			off_q  <= req.offset;
			len_q  <= req.length;
			slot_q <= req.slot;
		end
		if (cmd.check) begin
			j_q        <= '0;
			conf_row_q <= '0;
			free_q     <= free_idx;
			enq_go_q   <= (kind_q == KIND_ENQ) && !full;
			cpl_ok_q   <= (kind_q != KIND_ENQ) && cpl_ok;
			rslot_q    <= '0;
			rseq_q     <= '0;
			if (kind_q == KIND_ENQ) begin
				if (full) begin
					rk_q <= RK_FULL;
				end else begin
					rk_q    <= RK_ENQ_OK;
					rslot_q <= SLOT_W'(free_idx);
					rseq_q  <= next_seq_q;
				end
			end else if (cpl_ok) begin
				rk_q    <= RK_CPL_OK;
				rslot_q <= slot_q;
				rseq_q  <= eseq_q[slot_q[IDX_W-1:0]];
			end else begin
				rk_q    <= RK_CPL_REJ;
				rslot_q <= slot_q;
			end
		end
		if (cmd.cmp) begin
			conf_row_q[j_q] <= hit;
			j_q             <= j_q + 1'b1;
		end
		if (cmd.upd && enq_go_q) begin
			conf_q[free_q]   <= conf_row_q;
			ewr_q[free_q]    <= wr_q;
			estart_q[free_q] <= off_q;
			esize_q[free_q]  <= len_q;
			eseq_q[free_q]   <= next_seq_q;
		end
		if (cmd.emit1) begin
			rsp.result_kind  <= rk_q;
			rsp.out_slot     <= rslot_q;
			rsp.sequence_res <= rseq_q;
			rsp.out_is_write <= 1'b0;
			rsp.out_offset   <= '0;
			rsp.out_length   <= '0;
			rsp.last         <= (disp_q == '0);
		end
		if (cmd.scan) begin
			rsp.result_kind  <= RK_DISPATCH;
			rsp.out_slot     <= SLOT_W'(pick_idx);
			rsp.sequence_res <= eseq_q[pick_idx];
			rsp.out_is_write <= ewr_q[pick_idx];
			rsp.out_offset   <= estart_q[pick_idx];
			rsp.out_length   <= esize_q[pick_idx];
			rsp.last         <= ((disp_q & ~pick) == '0);
		end
	end

	a_run_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q & ~valid_q) == '0) else $error("running slot not valid");
	a_pick_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && disp_q != '0) |-> $onehot(pick)) else $error("pick");
	a_disp_run: assert property (@(posedge clk) disable iff (!arst_n)
		(disp_q & ~run_q) == '0) else $error("dispatch not running");
endmodule

### design/io_request_hazard_dispatcher.sv
// Top level of the in-order I/O request queue with address hazard check.
//
// req carries one word per request: kind 0 enqueues a read or write
// (is_write, offset, length), kind 1 completes a running slot (slot).
// rsp gives first one word for the request itself (accepted, queue full,
// completion done or rejected), then one dispatch word per newly issued
// entry, oldest first; last marks the final word of a request.
// A request is taken only when the block is idle. An enqueue that fits
// compares the new range against every slot, one slot a cycle, building
// a conflict row; other words skip that. Then come update and selection,
// and after that one result word per cycle while rsp is not stalled.
// A stalled rsp holds its word; the block waits and loses nothing.
// Reset empties the queue and clears the sequence counter; no clearing
// pass is needed.
module io_request_hazard_dispatcher import iohd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	iohd_req_if.sink   req,
	iohd_rsp_if.source rsp
);
	cmd_t cmd;
	sts_t sts;
	logic rdy;

	iohd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.sts      (sts),
		.cmd      (cmd),
		.in_valid (req.valid),
		.in_ready (rdy)
	);

	iohd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (rdy && req.valid)) else $error("ready mismatch");
endmodule

### bench/tb_pkg.sv
// Bench-side constants shared by the dispatcher testbench.
package tb_pkg;
	import iohd_pkg::*;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 400000;
endpackage

### bench/tb.sv
// Self-checking testbench for the I/O request hazard dispatcher.
module tb;
	import iohd_pkg::*;
	import tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             kind;
		logic             is_write;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic [SLOT_W-1:0] slot;
	} req_word_t;

	typedef struct packed {
		logic [RK_W-1:0]   rk;
		logic [SLOT_W-1:0] sl;
		logic [SEQ_W-1:0]  sq;
		logic              wr;
		logic [OFF_W-1:0]  off;
		logic [LEN_W-1:0]  len;
		logic              last;
	} rsp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	iohd_req_if req ();
	iohd_rsp_if rsp ();

	io_request_hazard_dispatcher u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	req_word_t pending_reqs[$];
	rsp_word_t expected_rsps[$];

	logic              q_valid[QDEPTH];
	logic              q_run[QDEPTH];
	logic              q_wr[QDEPTH];
	logic [OFF_W-1:0]  q_off[QDEPTH];
	logic [LEN_W-1:0]  q_len[QDEPTH];
	logic [SEQ_W-1:0]  q_seq[QDEPTH];
	logic [QDEPTH-1:0] q_older[QDEPTH];
	logic [SEQ_W-1:0]  seq_ctr;

	int mismatches = 0;
	int cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit quiet = 1'b0;
	bit hold_done = 1'b0;
	bit feeding = 1'b1;
	int sent = 0;
	int last_slot_run = 0;

	function automatic bit spans_meet(int a, int b);
		logic [OFF_W:0] ae, be;
		ae = {1'b0, q_off[a]} + q_len[a];
		be = {1'b0, q_off[b]} + q_len[b];
		return !((ae < {1'b0, q_off[b]}) || (be < {1'b0, q_off[a]}));
	endfunction

	function automatic void predict_dispatch(req_word_t w);
		rsp_word_t r;
		rsp_word_t batch[$];
		logic [QDEPTH-1:0] vm;
		int fs;
		bit blk;
		fs = -1;
		r = '0;
		if (w.kind == KIND_ENQ) begin
			for (int i = QDEPTH - 1; i >= 0; i--)
				if (!q_valid[i]) fs = i;
			if (fs < 0) begin
				r.rk = RK_FULL;
			end else begin
				for (int i = 0; i < QDEPTH; i++) vm[i] = q_valid[i];
				q_older[fs] = vm;
				q_valid[fs] = 1'b1;
				q_run[fs] = 1'b0;
				q_wr[fs] = w.is_write;
				q_off[fs] = w.offset;
				q_len[fs] = w.length;
				q_seq[fs] = seq_ctr;
				seq_ctr++;
				r.rk = RK_ENQ_OK;
				r.sl = fs[SLOT_W-1:0];
				r.sq = q_seq[fs];
			end
		end else if (q_valid[w.slot] && q_run[w.slot]) begin
			q_valid[w.slot] = 1'b0;
			q_run[w.slot] = 1'b0;
			for (int i = 0; i < QDEPTH; i++) q_older[i][w.slot] = 1'b0;
			q_older[w.slot] = '0;
			r.rk = RK_CPL_OK;
			r.sl = w.slot;
			r.sq = q_seq[w.slot];
		end else begin
			r.rk = RK_CPL_REJ;
			r.sl = w.slot;
		end
		batch.push_back(r);
		for (int i = 0; i < QDEPTH; i++) vm[i] = q_valid[i];
		for (int rank = 0; rank < QDEPTH; rank++)
			for (int i = 0; i < QDEPTH; i++) begin
				if (!q_valid[i] || $countones(q_older[i] & vm) != rank) continue;
				if (q_run[i]) continue;
				blk = 1'b0;
				for (int j = 0; j < QDEPTH; j++)
					if (q_valid[j] && q_older[i][j] && spans_meet(i, j) && (q_wr[i] || q_wr[j]))
						blk = 1'b1;
				if (!blk) begin
					q_run[i] = 1'b1;
					r = '0;
					r.rk = RK_DISPATCH;
					r.sl = i[SLOT_W-1:0];
					r.sq = q_seq[i];
					r.wr = q_wr[i];
					r.off = q_off[i];
					r.len = q_len[i];
					batch.push_back(r);
				end
			end
		batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k]) expected_rsps.push_back(batch[k]);
	endfunction

	function automatic req_word_t make_enq(bit wr, logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
		req_word_t w;
		w = '0;
		w.kind = KIND_ENQ;
		w.is_write = wr;
		w.offset = off;
		w.length = len;
		w.slot = SLOT_W'($urandom);
		return w;
	endfunction

	function automatic req_word_t make_cpl(logic [SLOT_W-1:0] s);
		req_word_t w;
		w = '0;
		w.kind = ~KIND_ENQ;
		w.slot = s;
		w.is_write = 1'($urandom);
		w.offset = OFF_W'({$urandom, $urandom});
		w.length = $urandom;
		return w;
	endfunction

	function automatic req_word_t rand_req();
		int p;
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
		p = $urandom_range(0, 99);
		if (p < 8) begin
			off = OFF_W'({$urandom, $urandom});
			len = $urandom;
		end else begin
			off = OFF_W'($urandom_range(0, 4095));
			len = $urandom_range(0, 300);
		end
		if (p < 55) return make_enq(1'($urandom), off, len);
		return make_cpl(SLOT_W'($urandom));
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < QDEPTH; i++) begin
			q_valid[i] = 1'b0;
			q_run[i] = 1'b0;
			q_older[i] = '0;
		end
		seq_ctr = '0;
		pending_reqs.push_back(make_cpl(4'd0));
		pending_reqs.push_back(make_enq(1'b0, '0, '0));
		pending_reqs.push_back(make_enq(1'b1, '0, '0));
		pending_reqs.push_back(make_enq(1'b0, 48'd1, 32'd5));
		pending_reqs.push_back(make_cpl(4'd1));
		pending_reqs.push_back(make_cpl(4'd0));
		pending_reqs.push_back(make_cpl(4'd0));
		pending_reqs.push_back(make_enq(1'b1, '1, '1));
		pending_reqs.push_back(make_enq(1'b0, 48'd0, 32'd9));
		pending_reqs.push_back(make_enq(1'b0, 48'd4, 32'd1));
		pending_reqs.push_back(make_enq(1'b1, 48'd10, 32'd2));
		pending_reqs.push_back(make_enq(1'b1, 48'd14, 32'd1));
		for (int i = 0; i < 12; i++)
			pending_reqs.push_back(make_enq(1'b0, 48'h8000_0000_0000 + OFF_W'(i), 32'hFFFF_FFFF));
		pending_reqs.push_back(make_enq(1'b1, 48'h5555_5555_5555, 32'hAAAA_AAAA));
		for (int i = 0; i < QDEPTH; i++) pending_reqs.push_back(make_cpl(SLOT_W'(i)));
		for (int i = 0; i < 157; i++) pending_reqs.push_back(rand_req());
		for (int i = 0; i < QDEPTH; i++) pending_reqs.push_back(make_cpl(SLOT_W'(i)));
		for (int i = 0; i < QDEPTH; i++) pending_reqs.push_back(make_cpl(SLOT_W'(i)));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.kind <= 1'b0;
			req.is_write <= 1'b0;
			req.offset <= '0;
			req.length <= '0;
			req.slot <= '0;
			gap_left <= 0;
		end else begin
			if (req.valid && req.ready) begin
				predict_dispatch(pending_reqs.pop_front());
				sent <= sent + 1;
			end
			if ((req.valid && !req.ready) || (!req.valid && gap_left > 0)) begin
				if (!req.valid) gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0 &&
				!(gap_left == 0 && !quiet && $urandom_range(0, 5) == 0)) begin
				req.valid <= 1'b1;
				{req.kind, req.is_write, req.offset, req.length, req.slot} <= pending_reqs[0];
			end else begin
				req.valid <= 1'b0;
				if (!quiet && pending_reqs.size() > 1) gap_left <= $urandom_range(1, 5);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected word kind=%0d", rsp.result_kind);
				end else if (expected_rsps[0] != {rsp.result_kind, rsp.out_slot, rsp.sequence_res,
					rsp.out_is_write, rsp.out_offset, rsp.out_length, rsp.last}) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch exp=%h act=%h", expected_rsps[0],
							{rsp.result_kind, rsp.out_slot, rsp.sequence_res, rsp.out_is_write,
							rsp.out_offset, rsp.out_length, rsp.last});
					void'(expected_rsps.pop_front());
				end else begin
					void'(expected_rsps.pop_front());
				end
			end
			if (!hold_done && sent == 60) begin
				hold_done <= 1'b1;
				hold_left <= 600;
				rsp.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				rsp.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 4);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (pending_reqs.size() < 40) quiet <= 1'b1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		wait (pending_reqs.size() == 0);
		wait (expected_rsps.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
